// File: design/sha256_pkg.sv
package sha256_pkg;

   localparam int unsigned QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] initial_hash(input logic [2:0] idx);
      logic [31:0] h;
      case (idx)
         3'd0: h = 32'h6a09e667;
         3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;
         3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;
         3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

endpackage

// File: design/sha256_queue.sv
module sha256_queue #(
   parameter int unsigned Depth = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  sha256_pkg::item_type  push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output sha256_pkg::item_type  pop_item
);
   import sha256_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   item_type            slot_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]   count_ff, count_in;
   logic                push_fire, pop_fire;

   assign push_ready = (count_ff != (PtrWidth+1)'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (PtrWidth+1)'(push_fire) - (PtrWidth+1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/sha256_engine.sv
module sha256_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  sha256_pkg::item_type item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_digest_word,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word
);
   import sha256_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] chain_ff [8];
   logic [31:0] var_ff [8];
   logic [31:0] sched_ff [16];
   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  round_ff, round_in;
   logic        finish_ff, finish_in;
   logic        second_ff, second_in;
   logic [2:0]  emit_ff, emit_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff;
   logic [2:0]  out_index_ff;
   logic        out_last_ff;

   logic        accept, start_load, do_round, do_add, do_pad, do_emit, do_restart;
   logic        pad_twice;
   logic [31:0] w_cur, s0, s1, w_new, big0, big1, chs, maj, t1;
   logic [5:0]  byte_pos;
   logic [4:0]  byte_lsb;

   assign accept   = item_valid && item_ready;
   assign w_cur    = sched_ff[0];
   assign s0       = {sched_ff[1][6:0], sched_ff[1][31:7]}
                   ^ {sched_ff[1][17:0], sched_ff[1][31:18]} ^ (sched_ff[1] >> 3);
   assign s1       = {sched_ff[14][16:0], sched_ff[14][31:17]}
                   ^ {sched_ff[14][18:0], sched_ff[14][31:19]} ^ (sched_ff[14] >> 10);
   assign w_new    = s1 + sched_ff[9] + s0 + sched_ff[0];
   assign big1     = {var_ff[4][5:0], var_ff[4][31:6]} ^ {var_ff[4][10:0], var_ff[4][31:11]}
                   ^ {var_ff[4][24:0], var_ff[4][31:25]};
   assign chs      = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign t1       = var_ff[7] + big1 + chs + round_const(round_ff) + w_cur;
   assign big0     = {var_ff[0][1:0], var_ff[0][31:2]} ^ {var_ff[0][12:0], var_ff[0][31:13]}
                   ^ {var_ff[0][21:0], var_ff[0][31:22]};
   assign maj      = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign pad_twice = (fill_ff >= 6'd56);
   assign byte_pos = fill_ff;
   assign byte_lsb = {~byte_pos[1:0], 3'b000};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      round_in     = round_ff;
      finish_in    = finish_ff;
      second_in    = second_ff;
      emit_in      = emit_ff;
      out_valid_in = out_valid_ff;
      item_ready   = 1'b0;
      start_load   = 1'b0;
      do_round     = 1'b0;
      do_add       = 1'b0;
      do_pad       = 1'b0;
      do_emit      = 1'b0;
      do_restart   = 1'b0;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               finish_in = item.end_of_message;
               if (item.byte_valid) begin
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     start_load = 1'b1;
                     second_in  = 1'b0;
                     bits_in    = bits_ff + 64'd512;
                     state_in   = ST_ROUND;
                  end else if (item.end_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (item.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            do_pad     = 1'b1;
            start_load = 1'b1;
            round_in   = '0;
            if (!second_ff) begin
               bits_in = bits_ff + {55'd0, fill_ff, 3'd0};
            end
            second_in = !second_ff && pad_twice;
            finish_in = !second_in ? 1'b0 : finish_ff;
            state_in  = ST_ROUND;
            if (!second_ff && !pad_twice) begin
               finish_in = 1'b0;
            end
            emit_in = '0;
         end
         ST_ROUND: begin
            do_round = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            do_add = 1'b1;
            if (finish_ff) begin
               state_in = ST_PAD;
            end else if (second_ff) begin
               state_in = ST_PAD;
            end else if (fill_ff == 6'd0 && bits_ff != 64'd0 && emit_ff == 3'd7) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               do_emit      = 1'b1;
               out_valid_in = 1'b1;
               emit_in      = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  do_restart = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (do_restart) begin
         fill_in = '0;
         bits_in = '0;
      end
   end

   // Phase tracking: after padded compression, emit or pad a second block.
   logic pad_phase_ff, pad_phase_in;
   always_comb begin
      pad_phase_in = pad_phase_ff;
      if (do_pad) begin
         pad_phase_in = 1'b1;
      end else if (do_restart) begin
         pad_phase_in = 1'b0;
      end
   end

   state_type state_next;
   always_comb begin
      state_next = state_in;
      if (do_add && pad_phase_ff) begin
         state_next = second_ff ? ST_PAD : ST_EMIT;
      end else if (do_add && finish_ff) begin
         state_next = ST_PAD;
      end else if (do_add) begin
         state_next = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         round_ff     <= '0;
         finish_ff    <= 1'b0;
         second_ff    <= 1'b0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
         pad_phase_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= initial_hash(3'(i));
         end
      end else begin
         state_ff     <= state_next;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         round_ff     <= start_load ? 6'd0 : round_in;
         finish_ff    <= finish_in;
         second_ff    <= second_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
         pad_phase_ff <= pad_phase_in;
         if (do_add) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + var_ff[i];
            end
         end else if (do_restart) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= initial_hash(3'(i));
            end
         end
      end
   end

   // The block is held as sixteen big-endian words. Padding rewrites every
   // byte at or above the fill position, or every byte of a second padded
   // block, and is loaded straight into the schedule in the same cycle.
   always_comb begin
      for (int w = 0; w < 16; w++) begin
         blk_in[w] = blk_ff[w];
      end
      if (accept && item.byte_valid) begin
         blk_in[byte_pos[5:2]][byte_lsb +: 8] = item.data_byte;
      end
      if (do_pad) begin
         for (int w = 0; w < 16; w++) begin
            for (int b = 0; b < 4; b++) begin
               if (second_ff) begin
                  blk_in[w][8*(3-b) +: 8] = 8'h00;
               end else if (6'(4*w + b) == fill_ff) begin
                  blk_in[w][8*(3-b) +: 8] = 8'h80;
               end else if (6'(4*w + b) > fill_ff) begin
                  blk_in[w][8*(3-b) +: 8] = 8'h00;
               end
            end
         end
         if (second_ff) begin
            blk_in[14] = bits_ff[63:32];
            blk_in[15] = bits_ff[31:0];
         end else if (!pad_twice) begin
            blk_in[14] = bits_in[63:32];
            blk_in[15] = bits_in[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < 16; w++) begin
         blk_ff[w] <= blk_in[w];
      end
      if (do_emit) begin
         out_word_ff  <= chain_ff[emit_ff];
         out_index_ff <= emit_ff;
         out_last_ff  <= (emit_ff == 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (start_load) begin
         for (int t = 0; t < 16; t++) begin
            sched_ff[t] <= blk_in[t];
         end
         for (int i = 0; i < 8; i++) begin
            var_ff[i] <= chain_ff[i];
         end
      end else if (do_round) begin
         for (int t = 0; t < 15; t++) begin
            sched_ff[t] <= sched_ff[t+1];
         end
         sched_ff[15] <= w_new;
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + big0 + maj;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_digest_word = out_word_ff;
   assign rsp_word_index  = out_index_ff;
   assign rsp_last_word   = out_last_ff;

endmodule

// File: design/sha256_byte_stream_hasher.sv
// SHA-256 hasher fed one message byte per request transfer.
// A request carries req_data_byte with req_byte_valid, and req_end_of_message
// to close the message; an end with no byte is allowed, so the empty message
// can be hashed. Closing a message yields eight response transfers carrying
// the digest words, word 0 first, with rsp_last_word on the eighth.
// Requests enter a four-entry queue; the engine behind it absorbs one byte per
// cycle while idle and takes none while it compresses a full 64-byte block,
// one round per cycle through a single round unit. A message end costs one or
// two padded blocks before the digest words appear, one per cycle while the
// receiver takes them.
// While the response receiver stalls, the held word stays on the port and the
// engine waits; the queue keeps taking requests until it fills.
// Reset is synchronous and active high. It restores the initial hash values,
// clears the byte and bit counts and empties the queue; no clearing pass is
// needed.
module sha256_byte_stream_hasher #(
   parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha256_pkg::*;

   item_type in_item, q_item;
   logic     q_valid, q_ready;

   assign in_item = '{data_byte: req_data_byte, byte_valid: req_byte_valid,
                      end_of_message: req_end_of_message};

   sha256_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(req_valid),
      .push_ready(req_ready),
      .push_item (in_item),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_item  (q_item)
   );

   sha256_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (q_valid),
      .item_ready     (q_ready),
      .item           (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word)
   );

endmodule

// File: sim/sha256_byte_stream_hasher_tb.sv
module sha256_byte_stream_hasher_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   class digest_scoreboard;
      logic [31:0]     chain[8];
      logic [7:0]      buffer[64];
      int unsigned     fill;
      logic [63:0]     bit_count;
      digest_word_type pending_words[$];
      int unsigned     errors;
      int unsigned     words_checked;
      int unsigned     messages;

      function new();
         errors = 0;
         words_checked = 0;
         messages = 0;
         foreach (buffer[i]) buffer[i] = 8'h00;
         restart();
      endfunction

      function void restart();
         chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
         chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
         chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
         chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
         fill = 0;
         bit_count = 64'd0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] k[64];
         logic [31:0] w[64];
         logic [31:0] v[8];
         logic [31:0] t1;
         logic [31:0] t2;
         k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
               32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
               32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
               32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
               32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
               32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
               32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
               32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
               32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
               32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
               32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
               32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
               32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
         for (int t = 0; t < 16; t++)
            w[t] = {buffer[4*t], buffer[4*t+1], buffer[4*t+2], buffer[4*t+3]};
         for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
         v = chain;
         for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] += v[i];
      endfunction

      function void note_request(logic [7:0] data, logic has_byte, logic finish);
         digest_word_type d;
         if (has_byte) begin
            buffer[fill] = data;
            fill = (fill + 1) % 64;
            if (fill == 0) begin
               compress();
               bit_count += 64'd512;
            end
         end
         if (finish) begin
            bit_count += 64'(fill * 8);
            buffer[fill] = 8'h80;
            for (int j = fill + 1; j < 64; j++) buffer[j] = 8'h00;
            if (fill >= 56) begin
               compress();
               for (int j = 0; j < 56; j++) buffer[j] = 8'h00;
            end
            for (int j = 0; j < 8; j++) buffer[56+j] = bit_count[63-8*j -: 8];
            compress();
            for (int j = 0; j < 8; j++) begin
               d.word = chain[j];
               d.index = 3'(j);
               d.last = (j == 7);
               pending_words.push_back(d);
            end
            messages++;
            restart();
         end
      endfunction

      function void check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_word_type e;
         words_checked++;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %0b",
                     $time, word, index, last);
            errors++;
            return;
         end
         e = pending_words.pop_front();
         if (word !== e.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
            errors++;
         end
         if (index !== e.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.index, index);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last_word expected %0b actual %0b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   digest_scoreboard scoreboard;
   logic             quiet_phase;
   int unsigned      idle_cycles;
   int unsigned      requests_sent;

   sha256_byte_stream_hasher u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_byte_valid(req_byte_valid),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         scoreboard.check_word(rsp_digest_word, rsp_word_index, rsp_last_word);
      if (!reset)
         rsp_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Watchdog expired at %0t", $time);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_request(logic [7:0] data, logic has_byte, logic finish);
      while (!quiet_phase && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_byte_valid <= has_byte;
      req_end_of_message <= finish;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_request(data, has_byte, finish);
      requests_sent++;
   endtask

   task automatic send_message(int unsigned length, logic empty_end);
      for (int i = 0; i < length; i++)
         send_request(8'($urandom), 1'b1, (i == length - 1) && !empty_end);
      if (empty_end || length == 0) send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      scoreboard = new();
      quiet_phase = 1'b0;
      requests_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_byte_valid = 1'b0;
      req_end_of_message = 1'b0;
      rsp_ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, byte with end, ignored items, field extremes.
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hff, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h55, 1'b0, 1'b0);
      send_request(8'haa, 1'b1, 1'b1);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      send_request(8'h00, 1'b0, 1'b1);

      // Padding boundaries: 55, 56 and 64 bytes.
      send_message(55, 1'b0);
      send_message(56, 1'b1);
      quiet_phase = 1'b1;
      send_message(64, 1'b0);
      quiet_phase = 1'b0;

      while (requests_sent < 200) begin
         case ($urandom_range(3))
            0: send_message($urandom_range(8), 1'($urandom_range(1)));
            1: send_message($urandom_range(20, 9), 1'($urandom_range(1)));
            2: send_request(8'($urandom), 1'b0, 1'b0);
            default: send_message($urandom_range(16), 1'($urandom_range(1)));
         endcase
      end
      req_valid <= 1'b0;

      while (scoreboard.pending_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Hashed %0d messages, %0d requests, %0d digest words checked.",
               scoreboard.messages, requests_sent, scoreboard.words_checked);
      $display("Covered empty messages, lone ends, padding boundaries and random bytes.");
      if (scoreboard.errors == 0 && scoreboard.pending_words.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
design/sha256_pkg.sv
design/sha256_queue.sv
design/sha256_engine.sv
design/sha256_byte_stream_hasher.sv
sim/sha256_byte_stream_hasher_tb.sv
